FILE: rtl/mtg_pkg.sv
// Package for the MT19937 generator: constants, controller states and tempering function.
package mtg_pkg;

	localparam logic [31:0] SEED_RESET = 32'd5489;
	localparam logic [31:0] INIT_MULT  = 32'd1812433253;
	localparam logic [31:0] TWIST_XOR  = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;

	typedef enum logic [2:0] {
		ST_FILL_START,
		ST_FILL_MUL,
		ST_FILL_ADD,
		ST_IDLE,
		ST_READ,
		ST_TWIST
	} state_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

FILE: rtl/mersenne_twister_generator.sv
// MT19937 generator top level: state memory, seed fill sequencer, per-word twist and temper.
//
// Channels: s_* takes draw requests (s_tdata[0] = restart), m_* returns one
// tempered 32-bit word per request, cfg_* writes the seed (always ready).
// The 624 state words sit in one memory with two registered read ports.
// Each draw twists exactly one word in place, the one it returns: a plain draw
// reads w[p+1] and w[p+397] in its read state and twists, tempers and writes
// back w[p] in its twist state. Requests are taken only in the idle state, so
// a new request waits until the draw before it has left its twist step.
// w[p] itself is held in a register from the previous draw's read (after a fill, the seed).
// A restart draw first refills the table from the seed: word 0 in a start step,
// then each further word in a multiply step and an add-and-write step, followed
// by the draw's read and twist steps.
// After reset the same fill runs from seed 5489; s_tready stays low until it
// ends. Seed writes only store the seed for the next fill.
// The result sits in an output register; the next request is accepted while
// it waits. If the receiver stalls, a further draw holds in its twist step
// until the output register frees.
module mersenne_twister_generator #(
	parameter int STATE_DEPTH  = 624,
	parameter int SHIFT_OFFSET = 397
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] random_word
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data   // [31:0] seed_value
);

	localparam int IDX_W = $clog2(STATE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_DEPTH - 1);
	localparam logic [IDX_W-1:0] OFF_IDX  = IDX_W'(SHIFT_OFFSET);
	localparam logic [IDX_W-1:0] WRAP_IDX = IDX_W'(STATE_DEPTH - SHIFT_OFFSET);

	mtg_pkg::state_t state_q, state_d;

	logic [31:0]      seed_q;
	logic [31:0]      prev_q;
	logic [31:0]      cur_q;
	logic [31:0]      product_s1;
	logic [IDX_W-1:0] fill_idx_q;
	logic [IDX_W-1:0] pos_q;
	logic             draw_pending_q;
	logic             out_valid_q;
	logic [31:0]      out_data_q;

	logic [31:0]      mem_q [STATE_DEPTH];
	logic [31:0]      rd1_q, rd2_q;
	logic [IDX_W-1:0] rd1_addr, rd2_addr;

	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [31:0]      mem_wd;
	logic             rd_en;
	logic             load_out;
	logic             accept;
	logic             out_free;

	logic [31:0] prev_mix;
	logic [31:0] fill_word;
	logic [31:0] joined;
	logic [31:0] mixed;
	logic [31:0] twisted;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign prev_mix  = prev_q ^ (prev_q >> 30);
	assign fill_word = product_s1 + {{(32-IDX_W){1'b0}}, fill_idx_q};

	assign joined  = {cur_q[31], rd1_q[30:0]};
	assign mixed   = (joined >> 1) ^ (joined[0] ? mtg_pkg::TWIST_XOR : 32'd0);
	assign twisted = rd2_q ^ mixed;

	assign rd1_addr = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
	assign rd2_addr = (pos_q >= WRAP_IDX) ? pos_q - WRAP_IDX : pos_q + OFF_IDX;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtg_pkg::ST_FILL_START: state_d = mtg_pkg::ST_FILL_MUL;
			mtg_pkg::ST_FILL_MUL:   state_d = mtg_pkg::ST_FILL_ADD;
			mtg_pkg::ST_FILL_ADD: begin
				if (fill_idx_q == LAST_IDX) begin
					state_d = draw_pending_q ? mtg_pkg::ST_READ : mtg_pkg::ST_IDLE;
				end else begin
					state_d = mtg_pkg::ST_FILL_MUL;
				end
			end
			mtg_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = s_tdata[0] ? mtg_pkg::ST_FILL_START : mtg_pkg::ST_READ;
				end
			end
			mtg_pkg::ST_READ:  state_d = mtg_pkg::ST_TWIST;
			mtg_pkg::ST_TWIST: begin
				if (out_free) state_d = mtg_pkg::ST_IDLE;
			end
			default: state_d = mtg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = pos_q;
		mem_wd   = twisted;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			mtg_pkg::ST_FILL_START: begin
				mem_we = 1'b1;
				mem_wa = '0;
				mem_wd = seed_q;
			end
			mtg_pkg::ST_FILL_MUL: ;
			mtg_pkg::ST_FILL_ADD: begin
				mem_we = 1'b1;
				mem_wa = fill_idx_q;
				mem_wd = fill_word;
			end
			mtg_pkg::ST_IDLE: s_tready = 1'b1;
			mtg_pkg::ST_READ: rd_en = 1'b1;
			mtg_pkg::ST_TWIST: begin
				mem_we   = out_free;
				load_out = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= mtg_pkg::ST_FILL_START;
			seed_q         <= mtg_pkg::SEED_RESET;
			fill_idx_q     <= '0;
			pos_q          <= '0;
			draw_pending_q <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) seed_q <= cfg_data;
			if (accept) draw_pending_q <= 1'b1;
			if (state_q == mtg_pkg::ST_FILL_START) begin
				fill_idx_q <= IDX_W'(1);
				pos_q      <= '0;
			end
			if (state_q == mtg_pkg::ST_FILL_ADD && fill_idx_q != LAST_IDX) begin
				fill_idx_q <= fill_idx_q + 1'b1;
			end
			if (load_out) begin
				pos_q          <= rd1_addr;
				draw_pending_q <= 1'b0;
				out_valid_q    <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == mtg_pkg::ST_FILL_START) begin
			prev_q <= seed_q;
			cur_q  <= seed_q;
		end
		if (state_q == mtg_pkg::ST_FILL_MUL) product_s1 <= mtg_pkg::INIT_MULT * prev_mix;
		if (state_q == mtg_pkg::ST_FILL_ADD) prev_q <= fill_word;
		if (load_out) begin
			cur_q      <= rd1_q;
			out_data_q <= mtg_pkg::temper(twisted);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		if (rd_en) begin
			rd1_q <= mem_q[rd1_addr];
			rd2_q <= mem_q[rd2_addr];
		end
	end

	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign cfg_ready = 1'b1;

endmodule

FILE: rtl/mtg_checker.sv
// Port-level checker for the MT19937 generator and its bind to the top level.
module mtg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [31:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken before draw finished");

	a_plain_draw_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tdata[0] |=> ##2 m_tvalid)
		else $error("plain draw gave no result in time");

	a_result_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> s_tready)
		else $error("result shown while block still busy");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("seed channel not ready");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);

FILE: sim/mersenne_twister_generator_test.sv
// Self-checking testbench for the MT19937 generator: directed table, random draws, seed phases.
module mersenne_twister_generator_test;

	localparam int DEPTH     = 624;
	localparam int OFFSET    = 397;
	localparam int PHASE_LEN = 630;

	typedef enum logic {ROW_DRAW, ROW_SEED} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        restart;
		logic        known;
		logic [31:0] word;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;   // [0] restart, [7:1] zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // [31:0] random_word
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = 32'd0; // [31:0] seed_value

	logic [31:0] mt_words [DEPTH];
	int          mt_pos;
	logic [31:0] mt_seed;
	logic [31:0] pending_words [$];
	int          mismatches = 0;
	int          send_idle_pct = 17;
	int          recv_idle_pct = 57;

	// seed 5489 stream values are the published MT19937 outputs
	dir_row_t dir_rows [23] = '{
		'{ROW_DRAW, 1'b0, 1'b1, 32'd3499211612},
		'{ROW_DRAW, 1'b0, 1'b1, 32'd581869302},
		'{ROW_DRAW, 1'b0, 1'b1, 32'd3890346734},
		'{ROW_DRAW, 1'b0, 1'b1, 32'd3586334585},
		'{ROW_DRAW, 1'b1, 1'b1, 32'd3499211612},
		'{ROW_DRAW, 1'b0, 1'b1, 32'd581869302},
		'{ROW_SEED, 1'b0, 1'b0, 32'h0000_0000},
		'{ROW_DRAW, 1'b0, 1'b1, 32'd3890346734},
		'{ROW_DRAW, 1'b1, 1'b0, 32'd0},
		'{ROW_DRAW, 1'b0, 1'b0, 32'd0},
		'{ROW_DRAW, 1'b0, 1'b0, 32'd0},
		'{ROW_SEED, 1'b0, 1'b0, 32'hFFFF_FFFF},
		'{ROW_DRAW, 1'b1, 1'b0, 32'd0},
		'{ROW_DRAW, 1'b0, 1'b0, 32'd0},
		'{ROW_DRAW, 1'b1, 1'b0, 32'd0},
		'{ROW_DRAW, 1'b1, 1'b0, 32'd0},
		'{ROW_DRAW, 1'b0, 1'b0, 32'd0},
		'{ROW_SEED, 1'b0, 1'b0, mtg_pkg::SEED_RESET},
		'{ROW_DRAW, 1'b1, 1'b1, 32'd3499211612},
		'{ROW_DRAW, 1'b0, 1'b1, 32'd581869302},
		'{ROW_SEED, 1'b0, 1'b0, 32'h8000_0000},
		'{ROW_DRAW, 1'b1, 1'b0, 32'd0},
		'{ROW_DRAW, 1'b0, 1'b0, 32'd0}
	};

	mersenne_twister_generator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void mt_refill();
		logic [31:0] prev;
		mt_words[0] = mt_seed;
		for (int k = 1; k < DEPTH; k++) begin
			prev = mt_words[k - 1];
			mt_words[k] = mtg_pkg::INIT_MULT * (prev ^ (prev >> 30)) + 32'(k);
		end
		mt_pos = DEPTH;
	endfunction

	function automatic void mt_twist();
		logic [31:0] joined;
		logic [31:0] mixed;
		for (int k = 0; k < DEPTH; k++) begin
			joined = (mt_words[k] & 32'h8000_0000) | (mt_words[(k + 1) % DEPTH] & 32'h7FFF_FFFF);
			mixed = joined >> 1;
			if (joined[0]) begin
				mixed = mixed ^ mtg_pkg::TWIST_XOR;
			end
			mt_words[k] = mt_words[(k + OFFSET) % DEPTH] ^ mixed;
		end
		mt_pos = 0;
	endfunction

	function automatic logic [31:0] mt_temper(input logic [31:0] v);
		logic [31:0] y;
		y = v ^ (v >> 11);
		y = y ^ ((y << 7) & mtg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	function automatic logic [31:0] mt_draw(input logic restart);
		logic [31:0] w;
		if (restart) begin
			mt_refill();
		end
		if (mt_pos >= DEPTH) begin
			mt_twist();
		end
		w = mt_words[mt_pos];
		mt_pos++;
		return mt_temper(w);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s: got %08h, want %08h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic send_draw(input logic restart, input logic known, input logic [31:0] word);
		logic [31:0] predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, restart};
		do @(posedge clk); while (!s_tready);
		predicted = mt_draw(restart);
		pending_words.push_back(known ? word : predicted);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_words.size() != 0);
	endtask

	task automatic write_seed(input logic [31:0] value);
		drain();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		mt_seed = value;
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, 32'd0);
			end else if (m_tdata !== pending_words[0]) begin
				report_mismatch("random_word", m_tdata, pending_words.pop_front());
			end else begin
				void'(pending_words.pop_front());
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		mt_seed = mtg_pkg::SEED_RESET;
		mt_refill();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_SEED) begin
				write_seed(dir_rows[r].word);
			end else begin
				send_draw(dir_rows[r].restart, dir_rows[r].known, dir_rows[r].word);
			end
		end

		for (int ph = 0; ph < 3; ph++) begin
			write_seed($urandom);
			send_idle_pct = (ph == 0) ? 17 : (ph == 1) ? 57 : 0;
			recv_idle_pct = (ph == 0) ? 57 : (ph == 1) ? 17 : 0;
			for (int i = 0; i < PHASE_LEN; i++) begin
				if (i == PHASE_LEN / 2) begin
					drain();
				end
				// phases 0 and 2 run past the end of the table into a second twist without a restart
				send_draw((i == 0) || (ph == 1 && $urandom_range(49) == 0), 1'b0, 32'd0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (pending_words.size() != 0) begin
			report_mismatch("missing beat", 32'd0, pending_words[0]);
		end
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: mersenne_twister_generator.f
rtl/mtg_pkg.sv
rtl/mersenne_twister_generator.sv
rtl/mtg_checker.sv
sim/mersenne_twister_generator_test.sv
